@@ design/coalescing_event_queue_unit_assert.svh @@
// Assertion macros for the coalescing event queue.
`ifndef COALESCING_EVENT_QUEUE_UNIT_ASSERT_SVH
`define COALESCING_EVENT_QUEUE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define EVQ_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("evq assertion failed");
`define EVQ_ASSERT_IMPL(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) cond |-> prop) \
        else $error("evq assertion failed");
`else
`define EVQ_ASSERT(label, prop)
`define EVQ_ASSERT_IMPL(label, cond, prop)
`endif
`endif

@@ design/evq_pkg.sv @@
package evq_pkg;

    localparam int ENTRY_W   = 84;
    localparam int KEY_W     = 52;
    localparam int S_DATA_W  = 96;
    localparam int M_DATA_W  = 160;
    localparam int MAX_OUT   = 16;

    typedef logic [ENTRY_W-1:0] entry_t;

    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_DRAIN = 2'd1;
    localparam logic [1:0] REQ_MARK  = 2'd2;
    localparam logic [1:0] REQ_EPOCH = 2'd3;

    localparam logic [2:0] RES_KEPT    = 3'd0;
    localparam logic [2:0] RES_LOST    = 3'd1;
    localparam logic [2:0] RES_DRAINED = 3'd2;
    localparam logic [2:0] RES_EMPTY   = 3'd3;
    localparam logic [2:0] RES_ACK     = 3'd4;

    localparam logic CFG_QUEUE_LIMIT   = 1'b0;
    localparam logic CFG_PROGRESS_KIND = 1'b1;

endpackage

@@ design/evq_ram.sv @@
module evq_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                   aclk,
    input  logic                   we,
    input  logic [AW-1:0]          wr_addr,
    input  evq_pkg::entry_t        wr_data,
    input  logic                   re,
    input  logic [AW-1:0]          rd_addr,
    output evq_pkg::entry_t        rd_data
);
    import evq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/coalescing_event_queue_unit.sv @@
// Coalescing event queue.
// Requests enter on the s_ stream (tuser = request type, tdata = event and
// drain limit); results leave on the m_ stream (tuser = result kind, tdata =
// event fields, queue count, counters and resync flag; tlast on the final
// result of a request). The cfg channel writes queue_limit (index 0) and
// progress_kind (index 1) and is always ready.
// One request is handled at a time; s_tready is high only while idle.
// Events live in a circular buffer in one synchronous RAM with one read
// and one write port, so each step waits on a RAM access:
//   mark/epoch and empty drain go straight to the result; push without eviction
//   may read the tail for a merge check, then appends; push that evicts first
//   scans entries for a progress event, and when the evicted entry is not the
//   head, shifts each entry behind it down with a read and a write;
//   drain reads and emits each drained event in turn.
// Reset empties the queue and clears counters and flag; queue_limit resets
// to 16 and progress_kind to 0. The RAM is not cleared.
// A stalled m_ side holds the result register and the request waits; no
// result is dropped.
module coalescing_event_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // event_code, job_number, stage_number, node_number, agent_number,
    // event_data, drain_limit, zero pad
    input  logic [evq_pkg::S_DATA_W-1:0]   s_tdata,
    // req_type
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_code, out_job, out_stage, out_node, out_agent, out_data,
    // queue_count, coalesced_total, evicted_total, resync_needed, zero pad
    output logic [evq_pkg::M_DATA_W-1:0]   m_tdata,
    // result_kind
    output logic [2:0]                     m_tuser,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_addr,
    input  logic [4:0]                     cfg_data
);
    import evq_pkg::*;

    `include "coalescing_event_queue_unit_assert.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TAIL = 4'd1;
    localparam logic [3:0] S_FULL = 4'd2;
    localparam logic [3:0] S_SCAN = 4'd3;
    localparam logic [3:0] S_SHRD = 4'd4;
    localparam logic [3:0] S_SHWR = 4'd5;
    localparam logic [3:0] S_APND = 4'd6;
    localparam logic [3:0] S_EMIT = 4'd7;
    localparam logic [3:0] S_DRD  = 4'd8;
    localparam logic [3:0] S_DOUT = 4'd9;

    logic [3:0]    state_reg;
    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [31:0]   merge_reg;
    logic [31:0]   evict_reg;
    logic          resync_reg;
    logic [4:0]    qlimit_reg;
    logic [3:0]    pkind_reg;
    entry_t        entry_reg;
    logic [2:0]    kind_reg;
    logic [AW-1:0] idx_reg;
    logic [4:0]    n_reg;
    logic [4:0]    k_reg;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [2:0]          m_tuser_reg;
    logic                m_tlast_reg;

    logic          ram_we;
    logic [AW-1:0] ram_wa;
    entry_t        ram_wd;
    logic          ram_re;
    logic [AW-1:0] ram_ra;
    entry_t        ram_rd;

    evq_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .re      (ram_re),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    logic          s_fire;
    logic          out_free;
    logic          out_load;
    logic [CW-1:0] eff_lim;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] tail_off;
    logic [AW-1:0] cnt_off;
    logic [4:0]    drain_n;
    logic          is_prog_in;
    logic          scan_hit;
    logic          d_last;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = ((state_reg == S_EMIT) || (state_reg == S_DOUT)) && out_free;
    assign cfg_ready = 1'b1;
    assign head_inc  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign tail_off  = AW'(count_reg - CW'(1));
    assign cnt_off   = AW'(count_reg);
    assign is_prog_in = (s_tdata[3:0] == pkind_reg);
    assign scan_hit  = (ram_rd[3:0] == pkind_reg);
    assign d_last    = ((k_reg + 5'd1) == n_reg);

    always_comb begin
        if (qlimit_reg == 5'd0) begin
            eff_lim = CW'(1);
        end else if (32'(qlimit_reg) > DEPTH) begin
            eff_lim = CW'(DEPTH);
        end else begin
            eff_lim = CW'(qlimit_reg);
        end
    end

    always_comb begin
        logic [8:0] n9;
        n9 = {4'b0, s_tdata[88:84]};
        if (n9 > 9'(count_reg)) begin
            n9 = 9'(count_reg);
        end
        if (n9 > 9'(MAX_OUT)) begin
            n9 = 9'(MAX_OUT);
        end
        drain_n = n9[4:0];
    end

    always_comb begin
        ram_we = 1'b0;
        ram_wa = '0;
        ram_wd = entry_reg;
        ram_re = 1'b0;
        ram_ra = head_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire && s_tuser == REQ_PUSH && is_prog_in && count_reg != '0) begin
                    ram_re = 1'b1;
                    ram_ra = phys(head_reg, tail_off);
                end
            end
            S_TAIL: begin
                if (ram_rd[KEY_W-1:0] == entry_reg[KEY_W-1:0]) begin
                    ram_we = 1'b1;
                    ram_wa = phys(head_reg, tail_off);
                end
            end
            S_FULL: begin
                ram_re = 1'b1;
                ram_ra = head_reg;
            end
            S_SCAN: begin
                ram_re = 1'b1;
                ram_ra = phys(head_reg, idx_reg + AW'(1));
            end
            S_SHRD: begin
                ram_re = 1'b1;
                ram_ra = phys(head_reg, idx_reg + AW'(1));
            end
            S_SHWR: begin
                ram_we = 1'b1;
                ram_wa = phys(head_reg, idx_reg);
                ram_wd = ram_rd;
            end
            S_APND: begin
                ram_we = (count_reg < CW'(DEPTH));
                ram_wa = phys(head_reg, cnt_off);
            end
            S_DRD: begin
                ram_re = 1'b1;
                ram_ra = head_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            merge_reg    <= '0;
            evict_reg    <= '0;
            resync_reg   <= 1'b0;
            qlimit_reg   <= 5'd16;
            pkind_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_addr == CFG_QUEUE_LIMIT) begin
                    qlimit_reg <= cfg_data;
                end else begin
                    pkind_reg <= cfg_data[3:0];
                end
            end
            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        entry_reg <= s_tdata[ENTRY_W-1:0];
                        k_reg     <= '0;
                        n_reg     <= drain_n;
                        case (s_tuser)
                            REQ_PUSH: begin
                                kind_reg  <= RES_KEPT;
                                state_reg <= (is_prog_in && count_reg != '0) ? S_TAIL
                                                                             : S_FULL;
                            end
                            REQ_DRAIN: begin
                                kind_reg  <= RES_EMPTY;
                                state_reg <= (drain_n == 5'd0) ? S_EMIT : S_DRD;
                            end
                            REQ_MARK: begin
                                resync_reg <= 1'b0;
                                kind_reg   <= RES_ACK;
                                state_reg  <= S_EMIT;
                            end
                            default: begin
                                count_reg  <= '0;
                                head_reg   <= '0;
                                merge_reg  <= '0;
                                evict_reg  <= '0;
                                resync_reg <= 1'b0;
                                kind_reg   <= RES_ACK;
                                state_reg  <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_TAIL: begin
                    if (ram_rd[KEY_W-1:0] == entry_reg[KEY_W-1:0]) begin
                        merge_reg <= sat_inc(merge_reg);
                        state_reg <= S_EMIT;
                    end else begin
                        state_reg <= S_FULL;
                    end
                end
                S_FULL: begin
                    idx_reg   <= '0;
                    state_reg <= (count_reg >= eff_lim) ? S_SCAN : S_APND;
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        evict_reg <= sat_inc(evict_reg);
                        if (idx_reg == '0) begin
                            head_reg  <= head_inc;
                            count_reg <= count_reg - CW'(1);
                            state_reg <= S_APND;
                        end else begin
                            state_reg <= S_SHRD;
                        end
                    end else if ((CW'(idx_reg) + CW'(1)) < count_reg) begin
                        idx_reg <= idx_reg + AW'(1);
                    end else begin
                        // no progress entry queued: drop the head
                        evict_reg  <= sat_inc(evict_reg);
                        head_reg   <= head_inc;
                        count_reg  <= count_reg - CW'(1);
                        resync_reg <= 1'b1;
                        kind_reg   <= RES_LOST;
                        state_reg  <= S_APND;
                    end
                end
                S_SHRD: begin
                    if ((CW'(idx_reg) + CW'(1)) < count_reg) begin
                        state_reg <= S_SHWR;
                    end else begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= S_APND;
                    end
                end
                S_SHWR: begin
                    idx_reg   <= idx_reg + AW'(1);
                    state_reg <= S_SHRD;
                end
                S_APND: begin
                    if (count_reg < CW'(DEPTH)) begin
                        count_reg <= count_reg + CW'(1);
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= kind_reg;
                        m_tlast_reg  <= 1'b1;
                        m_tdata_reg  <= {6'b0, resync_reg, evict_reg, merge_reg,
                                         5'(count_reg), 84'b0};
                        state_reg    <= S_IDLE;
                    end
                end
                S_DRD: begin
                    state_reg <= S_DOUT;
                end
                S_DOUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= RES_DRAINED;
                        m_tlast_reg  <= d_last;
                        m_tdata_reg  <= {6'b0, resync_reg, evict_reg, merge_reg,
                                         5'(count_reg - CW'(1)), ram_rd};
                        head_reg     <= head_inc;
                        count_reg    <= count_reg - CW'(1);
                        k_reg        <= k_reg + 5'd1;
                        state_reg    <= d_last ? S_IDLE : S_DRD;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `EVQ_ASSERT(a_count_bound, count_reg <= CW'(DEPTH))
    `EVQ_ASSERT_IMPL(a_accept_leaves_idle, s_fire, ##1 (state_reg != S_IDLE))
    `EVQ_ASSERT_IMPL(a_drain_nonempty, state_reg == S_DOUT, count_reg != '0)

endmodule

@@ bench/tb_coalescing_event_queue_unit.sv @@
module tb_coalescing_event_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import evq_pkg::*;

    typedef struct packed {
        logic [3:0]  code;
        logic [15:0] job;
        logic [7:0]  stage;
        logic [15:0] node;
        logic [7:0]  agent;
        logic [31:0] data;
    } event_t;

    typedef struct {
        logic [1:0] req;
        event_t     ev;
        logic [4:0] drain_limit;
    } request_t;

    typedef struct {
        logic [2:0]  kind;
        event_t      ev;
        logic        last;
        logic [4:0]  count;
        logic [31:0] coalesced;
        logic [31:0] evicted;
        logic        resync;
    } result_t;

    // Queue predictor and the expected-result store.
    class evq_scoreboard;
        event_t      entries[$];
        logic [31:0] merges;
        logic [31:0] evictions;
        logic        resync;
        logic [4:0]  limit_reg;
        logic [3:0]  progress_code;
        result_t     expected_results[$];
        int          failures;
        int          results_seen;

        function new();
            merges = '0;
            evictions = '0;
            resync = 1'b0;
            limit_reg = 5'd16;
            progress_code = 4'd0;
            failures = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic idx, logic [4:0] value);
            if (idx == CFG_QUEUE_LIMIT) limit_reg = value;
            else progress_code = value[3:0];
        endfunction

        function void add_result(logic [2:0] kind, event_t ev, logic last);
            result_t r;
            r.kind = kind;
            r.ev = ev;
            r.last = last;
            r.count = 5'(entries.size());
            r.coalesced = merges;
            r.evicted = evictions;
            r.resync = resync;
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void note_request(request_t rq);
            event_t none;
            event_t head;
            int     lim;
            int     n;
            int     idx;
            logic [2:0] kind;
            none = '0;
            case (rq.req)
                REQ_PUSH: begin
                    if (rq.ev.code == progress_code && entries.size() > 0 &&
                        entries[$].code == rq.ev.code && entries[$].job == rq.ev.job &&
                        entries[$].stage == rq.ev.stage && entries[$].node == rq.ev.node &&
                        entries[$].agent == rq.ev.agent) begin
                        entries[$].data = rq.ev.data;
                        if (merges != 32'hFFFF_FFFF) merges++;
                        add_result(RES_KEPT, none, 1'b1);
                    end else begin
                        lim = (limit_reg < 1) ? 1 : (limit_reg > 16 ? 16 : limit_reg);
                        kind = RES_KEPT;
                        if (entries.size() >= lim) begin
                            idx = -1;
                            foreach (entries[i])
                                if (idx < 0 && entries[i].code == progress_code) idx = i;
                            if (idx >= 0) begin
                                entries.delete(idx);
                            end else begin
                                entries.delete(0);
                                resync = 1'b1;
                                kind = RES_LOST;
                            end
                            if (evictions != 32'hFFFF_FFFF) evictions++;
                        end
                        if (entries.size() < 16) entries.insert(entries.size(), rq.ev);
                        add_result(kind, none, 1'b1);
                    end
                end
                REQ_DRAIN: begin
                    n = rq.drain_limit;
                    if (n > entries.size()) n = entries.size();
                    if (n > MAX_OUT) n = MAX_OUT;
                    if (n == 0) begin
                        add_result(RES_EMPTY, none, 1'b1);
                    end else begin
                        for (int k = 0; k < n; k++) begin
                            head = entries[0];
                            entries.delete(0);
                            add_result(RES_DRAINED, head, k == n - 1);
                        end
                    end
                end
                REQ_MARK: begin
                    resync = 1'b0;
                    add_result(RES_ACK, none, 1'b1);
                end
                default: begin
                    entries.delete();
                    merges = '0;
                    evictions = '0;
                    resync = 1'b0;
                    add_result(RES_ACK, none, 1'b1);
                end
            endcase
        endfunction

        function void check_result(result_t act);
            result_t e;
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: kind %0d", act.kind);
                failures++;
                return;
            end
            e = expected_results[0];
            expected_results.delete(0);
            if (act.kind !== e.kind) begin
                $error("result_kind: expected %0d, got %0d", e.kind, act.kind); failures++;
            end
            if (act.ev.code !== e.ev.code) begin
                $error("out_code: expected %0h, got %0h", e.ev.code, act.ev.code); failures++;
            end
            if (act.ev.job !== e.ev.job) begin
                $error("out_job: expected %0h, got %0h", e.ev.job, act.ev.job); failures++;
            end
            if (act.ev.stage !== e.ev.stage) begin
                $error("out_stage: expected %0h, got %0h", e.ev.stage, act.ev.stage);
                failures++;
            end
            if (act.ev.node !== e.ev.node) begin
                $error("out_node: expected %0h, got %0h", e.ev.node, act.ev.node); failures++;
            end
            if (act.ev.agent !== e.ev.agent) begin
                $error("out_agent: expected %0h, got %0h", e.ev.agent, act.ev.agent);
                failures++;
            end
            if (act.ev.data !== e.ev.data) begin
                $error("out_data: expected %0h, got %0h", e.ev.data, act.ev.data); failures++;
            end
            if (act.last !== e.last) begin
                $error("last: expected %0d, got %0d", e.last, act.last); failures++;
            end
            if (act.count !== e.count) begin
                $error("queue_count: expected %0d, got %0d", e.count, act.count); failures++;
            end
            if (act.coalesced !== e.coalesced) begin
                $error("coalesced_total: expected %0d, got %0d", e.coalesced, act.coalesced);
                failures++;
            end
            if (act.evicted !== e.evicted) begin
                $error("evicted_total: expected %0d, got %0d", e.evicted, act.evicted);
                failures++;
            end
            if (act.resync !== e.resync) begin
                $error("resync_needed: expected %0d, got %0d", e.resync, act.resync);
                failures++;
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [1:0]          s_tuser = REQ_PUSH;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [2:0]          m_tuser;
    logic                m_tlast;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_addr = CFG_QUEUE_LIMIT;
    logic [4:0]          cfg_data = '0;

    evq_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit rx_holdoff = 1'b0;
    int items_sent = 0;
    int cfg_writes = 0;

    always #2 aclk = ~aclk;

    coalescing_event_queue_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr),
        .cfg_data(cfg_data)
    );

    // Receiver backpressure; a holdoff wins over random stalls.
    always @(negedge aclk) begin
        if (rx_holdoff) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        result_t act;
        if (aresetn && m_tvalid && m_tready) begin
            act.kind      = m_tuser;
            act.ev.code   = m_tdata[3:0];
            act.ev.job    = m_tdata[19:4];
            act.ev.stage  = m_tdata[27:20];
            act.ev.node   = m_tdata[43:28];
            act.ev.agent  = m_tdata[51:44];
            act.ev.data   = m_tdata[83:52];
            act.count     = m_tdata[88:84];
            act.coalesced = m_tdata[120:89];
            act.evicted   = m_tdata[152:121];
            act.resync    = m_tdata[153];
            act.last      = m_tlast;
            sb.check_result(act);
        end
    end

    task automatic hold_receiver(int cycles);
        rx_holdoff = 1'b1;
        repeat (cycles) @(negedge aclk);
        rx_holdoff = 1'b0;
    endtask

    task automatic send_request(request_t rq);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = rq.req;
        s_tdata  = {7'b0, rq.drain_limit, rq.ev.data, rq.ev.agent, rq.ev.node,
                    rq.ev.stage, rq.ev.job, rq.ev.code};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(rq);
        items_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic settle();
        while (sb.expected_results.size() != 0) @(negedge aclk);
        // the block is idle once its last result has left
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] value);
        settle();
        cfg_valid = 1'b1;
        cfg_addr  = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, value);
        cfg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic request_t push_of(logic [3:0] code, logic [15:0] job,
                                         logic [31:0] data);
        request_t rq;
        rq.req = REQ_PUSH;
        rq.ev.code = code;
        rq.ev.job = job;
        rq.ev.stage = 8'h11;
        rq.ev.node = 16'h0202;
        rq.ev.agent = 8'h33;
        rq.ev.data = data;
        rq.drain_limit = '0;
        return rq;
    endfunction

    function automatic request_t ctl_of(logic [1:0] req, logic [4:0] n);
        request_t rq;
        rq.req = req;
        rq.ev = '0;
        rq.drain_limit = n;
        return rq;
    endfunction

    // Small key space so tail merges and progress evictions happen often.
    function automatic request_t random_request();
        request_t rq;
        int pick;
        pick = $urandom_range(99);
        rq.ev = 84'({$urandom, $urandom, $urandom});
        rq.drain_limit = 5'($urandom_range(31));
        if (pick < 70) begin
            rq.req = REQ_PUSH;
            if ($urandom_range(9) < 7) begin
                rq.ev.code  = ($urandom_range(1)) ? sb.progress_code
                                                  : 4'($urandom_range(15));
                rq.ev.job   = 16'($urandom_range(1));
                rq.ev.stage = 8'($urandom_range(1));
                rq.ev.node  = 16'h00F0;
                rq.ev.agent = $urandom_range(1) ? 8'hFF : 8'h00;
            end
        end else if (pick < 90) begin
            rq.req = REQ_DRAIN;
            if ($urandom_range(3) != 0) rq.drain_limit = 5'($urandom_range(6));
        end else if (pick < 96) begin
            rq.req = REQ_MARK;
        end else begin
            rq.req = REQ_EPOCH;
        end
        return rq;
    endfunction

    initial begin
        #2_000_000;
        $display("** coalescing_event_queue_unit: FAILED **");
        $finish;
    end

    initial begin
        int limits[6] = '{4, 0, 31, 1, 2, 16};
        int kinds[6]  = '{5, 15, 3, 0, 7, 9};
        int idle_mode;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: field extremes, every request, limit and merge cases
        send_request(ctl_of(REQ_DRAIN, 5'd4));
        send_request(push_of(4'h0, 16'h0001, 32'h0000_0000));
        send_request(push_of(4'h0, 16'h0001, 32'hFFFF_FFFF));
        send_request(push_of(4'hF, 16'hFFFF, 32'h1234_5678));
        begin
            request_t rq;
            rq = push_of(4'h0, 16'h0000, 32'hA5A5_5A5A);
            rq.ev.stage = 8'hFF; rq.ev.node = 16'hFFFF; rq.ev.agent = 8'hFF;
            send_request(rq);
            rq.ev = '0;
            send_request(rq);
        end
        send_request(ctl_of(REQ_DRAIN, 5'd0));
        send_request(ctl_of(REQ_DRAIN, 5'd2));
        send_request(ctl_of(REQ_DRAIN, 5'd31));
        send_request(ctl_of(REQ_DRAIN, 5'd1));
        for (int i = 0; i < 17; i++) send_request(push_of(4'h0, 16'(i), 32'(i)));
        send_request(ctl_of(REQ_DRAIN, 5'd16));
        write_reg(CFG_QUEUE_LIMIT, 5'd2);
        write_reg(CFG_PROGRESS_KIND, 5'd9);
        send_request(push_of(4'h1, 16'h0, 32'h1));
        send_request(push_of(4'h2, 16'h0, 32'h2));
        send_request(push_of(4'h3, 16'h0, 32'h3));
        send_request(ctl_of(REQ_MARK, 5'd0));
        send_request(ctl_of(REQ_EPOCH, 5'd0));

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_QUEUE_LIMIT, 5'(limits[ph]));
            write_reg(CFG_PROGRESS_KIND, 5'(kinds[ph]));
            for (int i = 0; i < 50; i++) begin
                if (i % 12 == 0) begin
                    idle_mode = $urandom_range(3);
                    send_idle_pct  = (idle_mode == 1) ? 78 : (idle_mode == 3 ? 32 : 0);
                    recv_stall_pct = (idle_mode == 2) ? 78 : (idle_mode == 3 ? 32 : 0);
                end
                if (ph == 2 && i == 10) begin
                    fork
                        hold_receiver(300);
                    join_none
                end
                send_request(random_request());
            end
            if (ph == 3) settle();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        settle();
        $display("run: %0d requests, %0d results checked, %0d register writes",
                 items_sent, sb.results_seen, cfg_writes);
        $display("covered pushes with merges and evictions, drains, acks and limit changes");
        if (sb.failures == 0) $display("** coalescing_event_queue_unit: PASSED **");
        else $display("** coalescing_event_queue_unit: FAILED **");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+design
design/evq_pkg.sv
design/evq_ram.sv
design/coalescing_event_queue_unit.sv
bench/tb_coalescing_event_queue_unit.sv
